// File: rtl/drc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types and constants of the debounced relay controller: register
// indexes, reset values, write cause codes and field widths.
// ----------------------------------------------------------------------------
package drc_pkg;

	// field widths
	localparam int unsigned TICK_W   = 32;
	localparam int unsigned BTN_N    = 3;
	localparam int unsigned CMD_W    = 4;
	localparam int unsigned POWER_W  = 17;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CAUSE_N  = 8;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE_TICKS = 2'd0,
		REG_POWER_LIMIT    = 2'd1
	} reg_idx_t;

	// reset values of the configuration registers
	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] POWER_LIMIT_RST = 16'd10000;

	// relay patterns
	localparam logic [1:0] RELAY_ALL_ON = 2'b11;
	localparam logic [1:0] RELAY_OFF    = 2'b00;

	// write causes, in the order the steps act within one period
	typedef enum logic [2:0] {
		CAUSE_ALL       = 3'd0,
		CAUSE_BTN1      = 3'd1,
		CAUSE_BTN2      = 3'd2,
		CAUSE_ON1       = 3'd3,
		CAUSE_OFF1      = 3'd4,
		CAUSE_ON2       = 3'd5,
		CAUSE_OFF2      = 3'd6,
		CAUSE_OVERPOWER = 3'd7
	} cause_t;

endpackage : drc_pkg
`default_nettype wire

// File: rtl/debounced_relay_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// An item waits in the input register until the result register is free; its
// results are then loaded into the result register and shown one per cycle
// while out_ready is high. Throughput: one item per cycle while each item causes
// at most one result and out_ready is high; more results hold the result register.
// Reset: relays off, buttons released, change times zero, registers to defaults.
// ----------------------------------------------------------------------------
// debounced_relay_controller
// Debounces three active-low buttons, applies button events, host commands
// and the over-power cutoff to a 2-bit relay pattern, and emits one item per
// relay write.
// ----------------------------------------------------------------------------
module debounced_relay_controller
	import drc_pkg::*;
(
	input  wire                        clk,
	input  wire                        arst_n,
	// input items
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire  [TICK_W-1:0]          tick_now,
	input  wire  [BTN_N-1:0]           button_levels,
	input  wire  [CMD_W-1:0]           host_commands,
	input  wire  signed [POWER_W-1:0]  power_dw,
	// result items
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [1:0]                 relay_pattern,
	output logic [2:0]                 write_cause,
	output logic                       last_write,
	// configuration writes
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire  [CFG_IDX_W-1:0]       cfg_index,
	input  wire  [CFG_W-1:0]           cfg_data
);

	// configuration registers
	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] power_limit_q;

	// controller state
	logic [1:0]        relay_q;
	logic [BTN_N-1:0]  stable_q;
	logic [TICK_W-1:0] change_time_q [BTN_N];

	// input register
	logic                      valid_s1;
	logic [TICK_W-1:0]         tick_s1;
	logic [BTN_N-1:0]          levels_s1;
	logic [CMD_W-1:0]          cmds_s1;
	logic signed [POWER_W-1:0] power_s1;

	// result register: one pattern per cause, pending writes as a mask
	logic [CAUSE_N-1:0] pending_q;
	logic [1:0]         patterns_q [CAUSE_N];

	// combinational results of the period in the input register
	logic [BTN_N-1:0]   btn_take;
	logic [BTN_N-1:0]   btn_event;
	logic [CAUSE_N-1:0] fire;
	logic [1:0]         pat [CAUSE_N];
	logic [1:0]         relay_next;
	logic               over_limit;

	// output side
	logic [2:0] head_idx;
	logic       out_take;
	logic       head_only;
	logic       bundle_free;
	logic       s1_adv;

	// configuration port is always ready; writes must happen only while idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= DEBOUNCE_RST;
			power_limit_q <= POWER_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE_TICKS: debounce_q    <= cfg_data;
				REG_POWER_LIMIT:    power_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// debouncers, relay steps and over-power check
	always_comb begin
		logic [TICK_W-1:0] elapsed;
		logic [1:0]        cur;
		for (int i = 0; i < BTN_N; i++) begin
			elapsed      = tick_s1 - change_time_q[i];
			btn_take[i]  = (~levels_s1[i] != stable_q[i]) &&
			               (elapsed > {{(TICK_W-CFG_W){1'b0}}, debounce_q});
			btn_event[i] = btn_take[i] & ~levels_s1[i];
		end
		over_limit = power_s1 > $signed({1'b0, power_limit_q});

		fire[CAUSE_ALL]       = btn_event[0];
		fire[CAUSE_BTN1]      = btn_event[1];
		fire[CAUSE_BTN2]      = btn_event[2];
		fire[CAUSE_ON1]       = cmds_s1[0];
		fire[CAUSE_OFF1]      = cmds_s1[1];
		fire[CAUSE_ON2]       = cmds_s1[2];
		fire[CAUSE_OFF2]      = cmds_s1[3];
		fire[CAUSE_OVERPOWER] = over_limit;

		cur = relay_q;
		if (fire[CAUSE_ALL]) cur = RELAY_ALL_ON;
		pat[CAUSE_ALL] = cur;
		if (fire[CAUSE_BTN1]) cur[0] = ~cur[0];
		pat[CAUSE_BTN1] = cur;
		if (fire[CAUSE_BTN2]) cur[1] = ~cur[1];
		pat[CAUSE_BTN2] = cur;
		if (fire[CAUSE_ON1]) cur[0] = 1'b1;
		pat[CAUSE_ON1] = cur;
		if (fire[CAUSE_OFF1]) cur[0] = 1'b0;
		pat[CAUSE_OFF1] = cur;
		if (fire[CAUSE_ON2]) cur[1] = 1'b1;
		pat[CAUSE_ON2] = cur;
		if (fire[CAUSE_OFF2]) cur[1] = 1'b0;
		pat[CAUSE_OFF2] = cur;
		if (fire[CAUSE_OVERPOWER]) cur[1] = 1'b0;
		pat[CAUSE_OVERPOWER] = cur;
		relay_next = cur;
	end

	// lowest pending write is the head of the output
	always_comb begin
		head_idx = 3'd0;
		for (int i = CAUSE_N - 1; i >= 0; i--) begin
			if (pending_q[i]) head_idx = 3'(i);
		end
	end

	assign head_only     = (pending_q & (pending_q - CAUSE_N'(1))) == '0;
	assign out_valid     = |pending_q;
	assign relay_pattern = patterns_q[head_idx];
	assign write_cause   = head_idx;
	assign last_write    = head_only;
	assign out_take      = out_valid & out_ready;

	// handshake between input register and result register
	assign bundle_free = !out_valid || (out_take && head_only);
	assign s1_adv      = valid_s1 && bundle_free;
	assign in_ready    = !valid_s1 || s1_adv;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1   <= tick_now;
			levels_s1 <= button_levels;
			cmds_s1   <= host_commands;
			power_s1  <= power_dw;
		end
	end

	// relay and debouncer state, updated as a period leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q  <= RELAY_OFF;
			stable_q <= '0;
			for (int i = 0; i < BTN_N; i++) change_time_q[i] <= '0;
		end else if (s1_adv) begin
			relay_q <= relay_next;
			for (int i = 0; i < BTN_N; i++) begin
				if (btn_take[i]) begin
					stable_q[i]      <= ~levels_s1[i];
					change_time_q[i] <= tick_s1;
				end
			end
		end
	end

	// pending mask of the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (s1_adv) begin
			pending_q <= fire;
		end else if (out_take) begin
			pending_q <= pending_q & (pending_q - CAUSE_N'(1));
		end
	end

	// patterns of the result register
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int i = 0; i < CAUSE_N; i++) patterns_q[i] <= pat[i];
		end
	end

endmodule : debounced_relay_controller
`default_nettype wire

// File: rtl/drc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drc_checker
// Port-level checks of the relay controller output, bound to the top level.
// ----------------------------------------------------------------------------
module drc_checker
	import drc_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire [1:0] relay_pattern,
	input wire [2:0] write_cause,
	input wire       last_write
);

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(relay_pattern) &&
			$stable(write_cause) && $stable(last_write))
		else $error("output item changed while stalled");

	// the rest of a period follows at once
	a_period_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_write |=> out_valid)
		else $error("period ended without a last write");

	// over-power always leaves relay two off
	a_overpower: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_cause == CAUSE_OVERPOWER |-> !relay_pattern[1])
		else $error("relay two on after over-power cutoff");

	// the all-on button drives both relays
	a_all_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_cause == CAUSE_ALL |-> relay_pattern == RELAY_ALL_ON)
		else $error("all-on write without both relays on");

endmodule : drc_checker

bind debounced_relay_controller drc_checker u_drc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.relay_pattern (relay_pattern),
	.write_cause   (write_cause),
	.last_write    (last_write)
);
`default_nettype wire
